### rtl/core/tlpc_pkg.sv
// Shared types, codes and constants for the tank level pump controller.
package tlpc_pkg;

  localparam int unsigned LEVEL_W = 16;
  localparam int unsigned BYTE_W  = 8;

  // Configuration register indexes and reset values.
  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t CFG_ZERO_REF  = 1'b0;
  localparam cfg_idx_t CFG_SWITCH_ON = 1'b1;

  localparam logic signed [LEVEL_W-1:0] ZERO_REF_RST  = 16'sd4300;
  localparam logic signed [LEVEL_W-1:0] SWITCH_ON_RST = 16'sd1000;

  localparam logic [BYTE_W-1:0]         FRAME_HEADER  = 8'hFF;
  localparam logic signed [LEVEL_W-1:0] LEVEL_ERR     = 16'sh8000;
  localparam logic signed [LEVEL_W-1:0] RAW_TIMEOUT   = -16'sd1;
  localparam logic signed [LEVEL_W-1:0] RAW_BAD_HDR   = -16'sd2;

  // User command characters.
  localparam logic [BYTE_W-1:0] CMD_ON    = 8'h31;  // '1'
  localparam logic [BYTE_W-1:0] CMD_OFF   = 8'h30;  // '0'
  localparam logic [BYTE_W-1:0] CMD_AUTO  = 8'h61;  // 'a'
  localparam logic [BYTE_W-1:0] CMD_FORCE = 8'h4F;  // 'O'
  localparam logic [BYTE_W-1:0] CMD_RAW   = 8'h72;  // 'r'

  // Position inside a sensor frame.
  localparam logic [1:0] FP_HEADER = 2'd0;
  localparam logic [1:0] FP_HIGH   = 2'd1;
  localparam logic [1:0] FP_LOW    = 2'd2;
  localparam logic [1:0] FP_CHECK  = 2'd3;

  typedef enum logic [1:0] {
    OP_SENSOR  = 2'd0,
    OP_TIMEOUT = 2'd1,
    OP_CMD     = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_GOOD      = 3'd1,
    EV_TIMEOUT   = 3'd2,
    EV_BAD_HDR   = 3'd3,
    EV_BAD_CSUM  = 3'd4,
    EV_RANGE     = 3'd5
  } event_t;

  typedef struct packed {
    logic [1:0]                frame_pos;
    logic [BYTE_W-1:0]         dist_hi;
    logic [BYTE_W-1:0]         dist_lo;
    logic                      relay;
    logic                      manual;
    logic                      forced;
    logic                      raw;
    logic signed [LEVEL_W-1:0] level;
  } state_t;

  localparam int unsigned OUT_DATA_W = 24;
  localparam int unsigned OUT_USER_W = 3;

endpackage

### rtl/core/tlpc_step.sv
// Next-state and event logic for one transaction: frame parsing, level, relay and commands.
module tlpc_step (
  input  tlpc_pkg::state_t                    st,
  input  logic [1:0]                          op,
  input  logic [tlpc_pkg::BYTE_W-1:0]         data_byte,
  input  logic signed [tlpc_pkg::LEVEL_W-1:0] zero_ref,
  input  logic signed [tlpc_pkg::LEVEL_W-1:0] switch_on,
  output tlpc_pkg::state_t                    st_nxt,
  output tlpc_pkg::event_t                    ev
);

  logic [tlpc_pkg::LEVEL_W-1:0]         distance;
  logic [tlpc_pkg::BYTE_W-1:0]          csum;
  logic signed [tlpc_pkg::LEVEL_W:0]    diff;
  logic signed [tlpc_pkg::LEVEL_W-1:0]  level_sat;
  logic                                 do_decide;

  assign distance = {st.dist_hi, st.dist_lo};
  assign csum = tlpc_pkg::FRAME_HEADER + st.dist_hi + st.dist_lo;
  assign diff = {zero_ref[tlpc_pkg::LEVEL_W-1], zero_ref}
              - $signed({2'b00, distance[tlpc_pkg::LEVEL_W-2:0]});

  // Only the negative side can overflow, since the distance is never negative.
  always_comb begin
    if (diff[tlpc_pkg::LEVEL_W] && !diff[tlpc_pkg::LEVEL_W-1]) begin
      level_sat = tlpc_pkg::LEVEL_ERR;
    end else begin
      level_sat = diff[tlpc_pkg::LEVEL_W-1:0];
    end
  end

  always_comb begin
    st_nxt    = st;
    ev        = tlpc_pkg::EV_NONE;
    do_decide = 1'b0;
    case (tlpc_pkg::op_t'(op))
      tlpc_pkg::OP_SENSOR: begin
        case (st.frame_pos)
          tlpc_pkg::FP_HEADER: begin
            if (data_byte == tlpc_pkg::FRAME_HEADER) begin
              st_nxt.frame_pos = tlpc_pkg::FP_HIGH;
            end else begin
              ev           = tlpc_pkg::EV_BAD_HDR;
              st_nxt.level = st.raw ? tlpc_pkg::RAW_BAD_HDR : tlpc_pkg::LEVEL_ERR;
              do_decide    = 1'b1;
            end
          end
          tlpc_pkg::FP_HIGH: begin
            st_nxt.dist_hi   = data_byte;
            st_nxt.frame_pos = tlpc_pkg::FP_LOW;
          end
          tlpc_pkg::FP_LOW: begin
            st_nxt.dist_lo   = data_byte;
            st_nxt.frame_pos = tlpc_pkg::FP_CHECK;
          end
          default: begin
            st_nxt.frame_pos = tlpc_pkg::FP_HEADER;
            do_decide        = 1'b1;
            if (csum != data_byte) begin
              ev = tlpc_pkg::EV_BAD_CSUM;
              if (!st.raw || distance[tlpc_pkg::LEVEL_W-1]) begin
                st_nxt.level = tlpc_pkg::LEVEL_ERR;
              end else begin
                st_nxt.level = -$signed(distance);
              end
            end else if (distance[tlpc_pkg::LEVEL_W-1]) begin
              ev           = tlpc_pkg::EV_RANGE;
              st_nxt.level = tlpc_pkg::LEVEL_ERR;
            end else begin
              ev           = tlpc_pkg::EV_GOOD;
              st_nxt.level = st.raw ? $signed(distance) : level_sat;
            end
          end
        endcase
      end
      tlpc_pkg::OP_TIMEOUT: begin
        ev               = tlpc_pkg::EV_TIMEOUT;
        st_nxt.frame_pos = tlpc_pkg::FP_HEADER;
        st_nxt.level     = st.raw ? tlpc_pkg::RAW_TIMEOUT : tlpc_pkg::LEVEL_ERR;
        do_decide        = 1'b1;
      end
      tlpc_pkg::OP_CMD: begin
        case (data_byte)
          tlpc_pkg::CMD_ON: begin
            st_nxt.relay  = 1'b1;
            st_nxt.manual = 1'b1;
          end
          tlpc_pkg::CMD_OFF: begin
            st_nxt.relay  = 1'b0;
            st_nxt.manual = 1'b1;
          end
          tlpc_pkg::CMD_AUTO: begin
            st_nxt.manual = 1'b0;
            st_nxt.forced = 1'b0;
            st_nxt.raw    = 1'b0;
          end
          tlpc_pkg::CMD_FORCE: begin
            st_nxt.forced = 1'b1;
          end
          tlpc_pkg::CMD_RAW: begin
            st_nxt.raw    = 1'b1;
            st_nxt.manual = 1'b1;
            st_nxt.relay  = 1'b0;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase

    // Relay decision after a finished measurement in normal mode.
    if (do_decide && !st.raw) begin
      if (st_nxt.level[tlpc_pkg::LEVEL_W-1] && st.relay && !st.forced) begin
        st_nxt.relay = 1'b0;
      end else if ((st_nxt.level > switch_on) && !st.relay && !st.manual) begin
        st_nxt.relay = 1'b1;
      end
    end
  end

endmodule

### rtl/core/tank_level_pump_controller.sv
// Top level of the tank level pump controller: channels, registers and state.
//
// Each input transaction is a sensor byte, a measurement timeout or a user
// command byte, and it yields exactly one output transaction carrying the relay
// drive, the latest level, the event code and the mode flags. A transaction
// is captured in the input register and then processed in a single pass
// into the output register, which presents its result, and one transaction
// per cycle is sustained while the output side keeps up; the input register
// holds one further transaction while a result waits. The two configuration
// registers must be written only while no transaction is in flight.
module tank_level_pump_controller #(
  parameter logic signed [tlpc_pkg::LEVEL_W-1:0] ZeroRefRst  = tlpc_pkg::ZERO_REF_RST,
  parameter logic signed [tlpc_pkg::LEVEL_W-1:0] SwitchOnRst = tlpc_pkg::SWITCH_ON_RST
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [tlpc_pkg::BYTE_W-1:0]         in_tdata,   // [7:0] data_byte
  input  logic [1:0]                          in_tuser,   // [1:0] op
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [0] relay_on, [16:1] level_mm, [17] manual_mode, [18] force_mode,
  // [19] raw_mode, [23:20] zero
  output logic [tlpc_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic [tlpc_pkg::OUT_USER_W-1:0]     out_tuser,  // [2:0] event_res
  input  logic                                cfg_we,
  input  tlpc_pkg::cfg_idx_t                  cfg_index,
  input  logic [tlpc_pkg::LEVEL_W-1:0]        cfg_wdata
);

  logic signed [tlpc_pkg::LEVEL_W-1:0] zero_ref_r;
  logic signed [tlpc_pkg::LEVEL_W-1:0] switch_on_r;

  logic                                in_valid_r;
  logic [1:0]                          in_op_r;
  logic [tlpc_pkg::BYTE_W-1:0]         in_byte_r;

  tlpc_pkg::state_t                    st_r;
  tlpc_pkg::state_t                    st_nxt;
  tlpc_pkg::event_t                    ev_nxt;

  logic                                out_valid_r;
  tlpc_pkg::state_t                    out_st_r;
  tlpc_pkg::event_t                    out_ev_r;

  logic                                advance;

  // The processing step moves whenever the output register is free or drained.
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_ref_r  <= ZeroRefRst;
      switch_on_r <= SwitchOnRst;
    end else if (cfg_we) begin
      case (cfg_index)
        tlpc_pkg::CFG_ZERO_REF:  zero_ref_r  <= $signed(cfg_wdata);
        tlpc_pkg::CFG_SWITCH_ON: switch_on_r <= $signed(cfg_wdata);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_op_r   <= in_tuser;
      in_byte_r <= in_tdata;
    end
  end

  tlpc_step u_step (
    .st        (st_r),
    .op        (in_op_r),
    .data_byte (in_byte_r),
    .zero_ref  (zero_ref_r),
    .switch_on (switch_on_r),
    .st_nxt    (st_nxt),
    .ev        (ev_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
      if (in_valid_r) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid_r) begin
      out_st_r <= st_nxt;
      out_ev_r <= ev_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_st_r.raw, out_st_r.forced, out_st_r.manual,
                       out_st_r.level, out_st_r.relay};
  assign out_tuser  = out_ev_r;

  // Raw mode is only ever entered together with manual mode.
  a_raw_implies_manual: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.raw |-> st_r.manual)
    else $error("raw mode set without manual mode");

  // In raw mode only commands may move the relay.
  a_raw_relay_hold: assert property (@(posedge clk) disable iff (!rst_n)
    advance && in_valid_r && st_r.raw && (in_op_r != tlpc_pkg::OP_CMD)
    |=> $stable(st_r.relay))
    else $error("relay changed by a measurement in raw mode");

  // A timeout always returns the parser to the frame start.
  a_timeout_resync: assert property (@(posedge clk) disable iff (!rst_n)
    advance && in_valid_r && (in_op_r == tlpc_pkg::OP_TIMEOUT)
    |=> st_r.frame_pos == tlpc_pkg::FP_HEADER)
    else $error("parser not at frame start after timeout");

  // A held input transaction is not lost while the output stalls.
  a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(in_op_r) && $stable(in_byte_r))
    else $error("input register lost a pending transaction");

endmodule

### sim/tank_level_pump_controller_tb.sv
// Self-checking testbench for the tank level pump controller stream block.
`timescale 1ns / 100ps

module tank_level_pump_controller_tb;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         CYCLE_LIMIT = 200000;
  localparam int         SEG_ITEMS   = 235;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
  } sensor_item_t;

  typedef struct packed {
    logic              relay;
    logic [15:0]       level;
    tlpc_pkg::event_t  ev;
    logic              manual;
    logic              forced;
    logic              raw;
  } pump_status_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;    // [7:0] data_byte
  logic [1:0]  in_tuser = '0;    // [1:0] op
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // [0] relay_on, [16:1] level_mm, [17] manual_mode, [18] force_mode,
  // [19] raw_mode, [23:20] zero
  logic [23:0] out_tdata;
  logic [2:0]  out_tuser;        // [2:0] event_res
  logic        cfg_we = 1'b0;
  tlpc_pkg::cfg_idx_t cfg_index = tlpc_pkg::CFG_ZERO_REF;
  logic [15:0] cfg_wdata = '0;

  sensor_item_t pending_bytes[$];
  pump_status_t expected_status[$];
  int           pushed_cnt = 0;
  int           results_seen = 0;
  int           err_cnt = 0;
  int           cycle_cnt = 0;
  int           in_idle_pct = 0;
  int           out_idle_pct = 0;

  // Controller state as the checker tracks it.
  logic [1:0]         frame_pos;
  logic [7:0]         dist_hi, dist_lo;
  logic               relay_drv, manual_flag, force_flag, raw_flag;
  logic signed [15:0] tank_level;
  logic signed [15:0] zero_ref_mm, switch_on_mm;

  tank_level_pump_controller DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void decide_relay();
    if (!raw_flag) begin
      if (tank_level < 0 && relay_drv && !force_flag)
        relay_drv = 1'b0;
      else if (tank_level > switch_on_mm && !relay_drv && !manual_flag)
        relay_drv = 1'b1;
    end
  endfunction

  task automatic pump_predict(input logic [1:0] op, input logic [7:0] b);
    pump_status_t st;
    logic [15:0]  distance;
    logic [7:0]   csum;
    int           diff;
    st.ev = tlpc_pkg::EV_NONE;
    if (op == tlpc_pkg::OP_SENSOR) begin
      case (frame_pos)
        tlpc_pkg::FP_HEADER: begin
          if (b == tlpc_pkg::FRAME_HEADER) begin
            frame_pos = tlpc_pkg::FP_HIGH;
          end else begin
            st.ev = tlpc_pkg::EV_BAD_HDR;
            tank_level = raw_flag ? tlpc_pkg::RAW_BAD_HDR : tlpc_pkg::LEVEL_ERR;
            decide_relay();
          end
        end
        tlpc_pkg::FP_HIGH: begin
          dist_hi = b;
          frame_pos = tlpc_pkg::FP_LOW;
        end
        tlpc_pkg::FP_LOW: begin
          dist_lo = b;
          frame_pos = tlpc_pkg::FP_CHECK;
        end
        default: begin
          distance = {dist_hi, dist_lo};
          csum = tlpc_pkg::FRAME_HEADER + dist_hi + dist_lo;
          frame_pos = tlpc_pkg::FP_HEADER;
          if (csum != b) begin
            st.ev = tlpc_pkg::EV_BAD_CSUM;
            if (!raw_flag || distance[15])
              tank_level = tlpc_pkg::LEVEL_ERR;
            else
              tank_level = -$signed(distance);
          end else if (distance[15]) begin
            st.ev = tlpc_pkg::EV_RANGE;
            tank_level = tlpc_pkg::LEVEL_ERR;
          end else begin
            st.ev = tlpc_pkg::EV_GOOD;
            if (raw_flag) begin
              tank_level = distance;
            end else begin
              diff = int'(zero_ref_mm) - int'(distance);
              tank_level = (diff < -32768) ? tlpc_pkg::LEVEL_ERR : 16'(diff);
            end
          end
          decide_relay();
        end
      endcase
    end else if (op == tlpc_pkg::OP_TIMEOUT) begin
      st.ev = tlpc_pkg::EV_TIMEOUT;
      frame_pos = tlpc_pkg::FP_HEADER;
      tank_level = raw_flag ? tlpc_pkg::RAW_TIMEOUT : tlpc_pkg::LEVEL_ERR;
      decide_relay();
    end else if (op == tlpc_pkg::OP_CMD) begin
      case (b)
        tlpc_pkg::CMD_ON: begin
          relay_drv = 1'b1;
          manual_flag = 1'b1;
        end
        tlpc_pkg::CMD_OFF: begin
          relay_drv = 1'b0;
          manual_flag = 1'b1;
        end
        tlpc_pkg::CMD_AUTO: begin
          manual_flag = 1'b0;
          force_flag = 1'b0;
          raw_flag = 1'b0;
        end
        tlpc_pkg::CMD_FORCE: force_flag = 1'b1;
        tlpc_pkg::CMD_RAW: begin
          raw_flag = 1'b1;
          manual_flag = 1'b1;
          relay_drv = 1'b0;
        end
        default: ;
      endcase
    end
    st.relay  = relay_drv;
    st.level  = tank_level;
    st.manual = manual_flag;
    st.forced = force_flag;
    st.raw    = raw_flag;
    expected_status.insert(expected_status.size(), st);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      err_cnt++;
    end
  endtask

  task automatic push_item(input logic [1:0] op, input logic [7:0] data);
    sensor_item_t it;
    it.op = op;
    it.data = data;
    pending_bytes.insert(pending_bytes.size(), it);
    pushed_cnt++;
  endtask

  task automatic push_frame(input logic [7:0] hi, input logic [7:0] lo, input bit good);
    logic [7:0] csum;
    csum = tlpc_pkg::FRAME_HEADER + hi + lo;
    if (!good)
      csum = csum + 8'($urandom_range(1, 255));
    push_item(tlpc_pkg::OP_SENSOR, tlpc_pkg::FRAME_HEADER);
    push_item(tlpc_pkg::OP_SENSOR, hi);
    push_item(tlpc_pkg::OP_SENSOR, lo);
    push_item(tlpc_pkg::OP_SENSOR, csum);
  endtask

  function automatic logic [7:0] pick_command();
    case ($urandom_range(7))
      0:       return tlpc_pkg::CMD_ON;
      1:       return tlpc_pkg::CMD_OFF;
      2, 3:    return tlpc_pkg::CMD_AUTO;
      4:       return tlpc_pkg::CMD_FORCE;
      5:       return tlpc_pkg::CMD_RAW;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic write_reg(input tlpc_pkg::cfg_idx_t idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == tlpc_pkg::CFG_ZERO_REF)
      zero_ref_mm = val;
    else
      switch_on_mm = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every transaction sent so far has produced its result.
  task automatic settle();
    do @(posedge clk);
    while (results_seen != pushed_cnt);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin : drive_in
    sensor_item_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        pump_predict(in_tuser, in_tdata);
      if (!in_tvalid || in_tready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
          nxt = pending_bytes.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= nxt.op;
          in_tdata  <= nxt.data;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : watch_out
    pump_status_t want;
    out_tready <= ($urandom_range(99) >= out_idle_pct);
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (expected_status.size() == 0) begin
        $error("result transaction with no expectation pending");
        err_cnt++;
      end else begin
        want = expected_status.pop_front();
        check_field("relay_on", want.relay, out_tdata[0]);
        check_field("level_mm", $signed(want.level), $signed(out_tdata[16:1]));
        check_field("event_res", want.ev, out_tuser);
        check_field("manual_mode", want.manual, out_tdata[17]);
        check_field("force_mode", want.forced, out_tdata[18]);
        check_field("raw_mode", want.raw, out_tdata[19]);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("[tank_level_pump_controller] ERROR");
      $finish;
    end
  end

  initial begin
    int          seg, seg_start, sel, k;
    logic [15:0] rnd_dist, zr, so;
    logic [7:0]  csum;
    frame_pos    = tlpc_pkg::FP_HEADER;
    dist_hi      = '0;
    dist_lo      = '0;
    relay_drv    = 1'b0;
    manual_flag  = 1'b0;
    force_flag   = 1'b0;
    raw_flag     = 1'b0;
    tank_level   = '0;
    zero_ref_mm  = tlpc_pkg::ZERO_REF_RST;
    switch_on_mm = tlpc_pkg::SWITCH_ON_RST;
    in_idle_pct  = 21;
    out_idle_pct = 55;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part with the reset register values.
    push_frame(8'h00, 8'h00, 1'b1);
    push_frame(8'hFF, 8'hFF, 1'b1);
    push_frame(8'h12, 8'h34, 1'b0);
    push_item(tlpc_pkg::OP_SENSOR, 8'h00);
    push_item(tlpc_pkg::OP_SENSOR, tlpc_pkg::FRAME_HEADER);
    push_item(tlpc_pkg::OP_TIMEOUT, 8'hFF);
    push_item(OP_UNUSED, 8'hFF);
    push_item(tlpc_pkg::OP_CMD, tlpc_pkg::CMD_ON);
    push_item(tlpc_pkg::OP_CMD, tlpc_pkg::CMD_OFF);
    push_item(tlpc_pkg::OP_CMD, tlpc_pkg::CMD_FORCE);
    push_item(tlpc_pkg::OP_CMD, 8'h00);
    push_item(tlpc_pkg::OP_CMD, tlpc_pkg::CMD_RAW);
    // Checksum failure on a distance beyond the positive range, in raw mode.
    push_frame(8'h80, 8'h00, 1'b0);
    push_item(tlpc_pkg::OP_CMD, tlpc_pkg::CMD_AUTO);
    settle();

    for (seg = 0; seg < 6; seg++) begin
      in_idle_pct  = (seg < 2) ? 21 : (seg < 4) ? 55 : 0;
      out_idle_pct = (seg < 2) ? 55 : (seg < 4) ? 21 : 0;
      case (seg)
        0: begin zr = 16'h7FFF; so = 16'h8000; end
        1: begin zr = 16'h8000; so = 16'h7FFF; end
        2: begin zr = tlpc_pkg::ZERO_REF_RST; so = tlpc_pkg::SWITCH_ON_RST; end
        3: begin
          zr = 16'($urandom_range(1000, 8000));
          so = 16'($urandom_range(0, 3500)) - 16'd500;
        end
        4: begin zr = '0; so = '0; end
        default: begin zr = 16'($urandom); so = 16'($urandom); end
      endcase
      write_reg(tlpc_pkg::CFG_ZERO_REF, zr);
      write_reg(tlpc_pkg::CFG_SWITCH_ON, so);

      seg_start = pushed_cnt;
      while (pushed_cnt - seg_start < SEG_ITEMS) begin
        sel = $urandom_range(99);
        if ($urandom_range(9) < 7)
          rnd_dist = 16'($urandom_range(0, 9000));
        else
          rnd_dist = 16'($urandom);
        if (sel < 50) begin
          push_frame(rnd_dist[15:8], rnd_dist[7:0], 1'b1);
        end else if (sel < 55) begin
          // A command arriving in the middle of a frame must not disturb the parser.
          csum = tlpc_pkg::FRAME_HEADER + rnd_dist[15:8] + rnd_dist[7:0];
          push_item(tlpc_pkg::OP_SENSOR, tlpc_pkg::FRAME_HEADER);
          push_item(tlpc_pkg::OP_SENSOR, rnd_dist[15:8]);
          push_item(tlpc_pkg::OP_CMD, pick_command());
          push_item(tlpc_pkg::OP_SENSOR, rnd_dist[7:0]);
          push_item(tlpc_pkg::OP_SENSOR, csum);
        end else if (sel < 65) begin
          push_frame(rnd_dist[15:8], rnd_dist[7:0], 1'b0);
        end else if (sel < 73) begin
          push_item(tlpc_pkg::OP_SENSOR, tlpc_pkg::FRAME_HEADER);
          k = $urandom_range(0, 2);
          repeat (k) push_item(tlpc_pkg::OP_SENSOR, 8'($urandom));
          push_item(tlpc_pkg::OP_TIMEOUT, 8'($urandom));
        end else if (sel < 80) begin
          push_item(tlpc_pkg::OP_SENSOR, 8'($urandom_range(0, 254)));
        end else if (sel < 93) begin
          push_item(tlpc_pkg::OP_CMD, pick_command());
        end else if (sel < 97) begin
          push_item(tlpc_pkg::OP_TIMEOUT, 8'($urandom));
        end else begin
          push_item(OP_UNUSED, 8'($urandom));
        end
      end
      settle();
    end

    if (err_cnt == 0)
      $display("[tank_level_pump_controller] OK");
    else
      $display("[tank_level_pump_controller] ERROR");
    $finish;
  end

endmodule

### tank_level_pump_controller.f
rtl/core/tlpc_pkg.sv
rtl/core/tlpc_step.sv
rtl/core/tank_level_pump_controller.sv
sim/tank_level_pump_controller_tb.sv
